// ===== hdl/rnt_pkg.sv =====
`default_nettype none

package rnt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam int OUTCOME_W     = 3;
  localparam int ENTRY_COUNT_W = 5;

  // request actions
  localparam logic [1:0] ACT_ADD     = 2'd0;
  localparam logic [1:0] ACT_LKP_LLA = 2'd1;
  localparam logic [1:0] ACT_LKP_MAC = 2'd2;
  localparam logic [1:0] ACT_LKP_ALL = 2'd3;

  // result outcomes
  localparam logic [OUTCOME_W-1:0] OUT_MISS  = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_HIT   = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_ADDED = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_DUP   = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_FULL  = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] vlan;
    logic [47:0] mac;
    logic [63:0] lla_high;
    logic [63:0] lla_low;
  } rnt_req_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0]     outcome;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } rnt_rsp_t;

  typedef struct packed {
    logic [11:0] vlan;
    logic [47:0] mac;
    logic [63:0] lla_high;
    logic [63:0] lla_low;
  } rnt_entry_t;

  typedef struct packed {
    logic start;   // latch request, restart scan
    logic scan;    // issue next slot read
    logic finish;  // resolve outcome, write back, load result
  } rnt_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } rnt_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } rnt_state_t;

endpackage

`default_nettype wire

// ===== hdl/rnt_ctrl.sv =====
`default_nettype none

module rnt_ctrl
  import rnt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire rnt_sts_t sts,
  output rnt_cmd_t      cmd
);

  rnt_state_t state_r;
  rnt_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.scan   = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the result register can take the new result
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/rnt_dp.sv =====
`default_nettype none

module rnt_dp
  import rnt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire rnt_req_t in_data,
  input  wire rnt_cmd_t cmd,
  output rnt_sts_t      sts,
  output logic          out_valid,
  input  wire logic     out_ready,
  output rnt_rsp_t      out_data
);

  rnt_req_t   req_r;
  rnt_entry_t mem [ENTRIES];
  rnt_entry_t mem_q_r;

  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             hit_r, hit_nxt;
  logic             out_valid_r, out_valid_nxt;
  rnt_rsp_t         out_data_r;

  logic                 issue;
  logic                 vlan_ok, mac_ok, lla_ok, match;
  logic                 full;
  logic                 do_write;
  logic [OUTCOME_W-1:0] outcome;
  rnt_entry_t           wr_entry;

  always_comb begin
    issue   = cmd.scan && (idx_r != count_r);
    vlan_ok = (req_r.vlan == 12'd0) || (req_r.vlan == mem_q_r.vlan);
    mac_ok  = (req_r.action == ACT_LKP_LLA) || (req_r.mac == mem_q_r.mac);
    lla_ok  = (req_r.action == ACT_LKP_MAC) ||
              ((req_r.lla_high == mem_q_r.lla_high) &&
               (req_r.lla_low == mem_q_r.lla_low));
    match   = rd_pend_r && vlan_ok && mac_ok && lla_ok;
    full    = (count_r == CNT_W'(ENTRIES));

    if (req_r.action == ACT_ADD) begin
      // duplicate check wins over full
      if (hit_r) begin
        outcome = OUT_DUP;
      end else if (full) begin
        outcome = OUT_FULL;
      end else begin
        outcome = OUT_ADDED;
      end
    end else begin
      outcome = hit_r ? OUT_HIT : OUT_MISS;
    end

    do_write = cmd.finish && (outcome == OUT_ADDED);

    wr_entry.vlan     = req_r.vlan;
    wr_entry.mac      = req_r.mac;
    wr_entry.lla_high = req_r.lla_high;
    wr_entry.lla_low  = req_r.lla_low;

    idx_nxt       = cmd.start ? '0 : (issue ? idx_r + 1'b1 : idx_r);
    rd_pend_nxt   = issue;
    hit_nxt       = cmd.start ? 1'b0 : (hit_r | match);
    count_nxt     = do_write ? count_r + 1'b1 : count_r;
    out_valid_nxt = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

    sts.scan_done = (idx_r == count_r) && !rd_pend_r;
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r <= in_data;
    end
    if (cmd.finish) begin
      out_data_r.outcome     <= outcome;
      out_data_r.entry_count <= ENTRY_COUNT_W'(count_nxt);
    end
  end

  // slot store: slots fill in order, so slots below count_r are the valid ones
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[count_r[IDX_W-1:0]] <= wr_entry;
    end
    if (issue) begin
      mem_q_r <= mem[idx_r[IDX_W-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hdl/router_neighbor_table.sv =====
// Router neighbor table: exact-match lookup over a fixed set of router slots.
// Input channel (in_valid/in_ready/in_data) carries one request: an add or
// a lookup by link-local address, by MAC, or by both. VLAN 0 matches any slot.
// Output channel (out_valid/out_ready/out_data) returns one transfer per
// request: outcome code and the number of slots held after the request.
// Timing: one request at a time. The scan reads one slot per cycle from the
// slot store over the filled slots only, so a request takes longer the more
// slots are held; in_ready rises in the same cycle as out_valid.
// Adds are written at the end of the scan into the next free slot.
// Reset (rst_n low, synchronous) empties the table and drops any pending
// result; slot contents are not cleared, the fill count marks them unused.
// Receiver stall: the result register holds its transfer; a following
// request is still accepted and scanned, and waits only to load its result.
`default_nettype none

module router_neighbor_table
  import rnt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire rnt_req_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output rnt_rsp_t      out_data
);

  rnt_cmd_t cmd;
  rnt_sts_t sts;

  // sequencer: idle -> scan -> finish
  rnt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // request register, slot store, compare, fill count, result register
  rnt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // one request in flight: no new transfer right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // a result is only loaded when the result register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.out_free)
    else $error("result loaded over a pending transfer");

  // scan start and finish never coincide
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.start, cmd.scan, cmd.finish}) <= 1)
    else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire
